[design/assert_macros.svh]
// Assertion macros shared by the RTL modules of the postfix evaluator.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pse_pkg.sv]
// Package of the postfix evaluator: sizes, token and status codes, command type.
// No dependencies; used by every module of the block except pse_ram.
package pse_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int LIT_W       = 31;

   // token kinds
   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_OPER   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // operator characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // result status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_DIVZERO   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;

   // classified commands
   typedef enum logic [3:0] {
      CMD_PUSH,
      CMD_END,
      CMD_UNKNOWN,
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_DIV,
      CMD_REM,
      CMD_POW
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [LIT_W-1:0]  literal;
   } cmd_type;

   // front to back: head of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

endpackage

[design/postfix_stack_evaluator.sv]
// Postfix evaluator: a token is registered into the front queue; the back pops it when idle.
// Back steps: push in idle; add/sub/mul read and compute, then write back; end reads, responds;
// divide/remainder and power iterate (divider, square-and-multiply); errors go to the response.
// Up to two tokens queue ahead of the back; the result sits in an output register.
// Synchronous active-high reset empties the queue, the stack and the result register.
module postfix_stack_evaluator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_token_kind,
   input  logic [pse_pkg::LIT_W-1:0]   req_literal,
   input  logic [7:0]                  req_opcode,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_answer,
   output logic [2:0]                  rsp_status
);

   pse_pkg::cmd_head_type head;
   logic                  pop;

   pse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_token_kind (req_token_kind),
      .req_literal    (req_literal),
      .req_opcode     (req_opcode),
      .head           (head),
      .pop            (pop)
   );

   pse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status)
   );

endmodule

[design/pse_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies; holds the operand stack.
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[design/pse_front.sv]
// Front end: accepts tokens, classifies them into commands, queues them (2 deep).
// Depends on pse_pkg.
module pse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_token_kind,
   input  logic [pse_pkg::LIT_W-1:0]   req_literal,
   input  logic [7:0]                  req_opcode,
   output pse_pkg::cmd_head_type       head,
   input  logic                        pop
);

   pse_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   pse_pkg::cmd_type cls;
   logic             keep;
   logic             push;

   // classify the token; spaces and undefined kinds are dropped
   always_comb begin
      cls.literal = req_literal;
      cls.op      = pse_pkg::CMD_UNKNOWN;
      keep        = 1'b1;
      unique case (req_token_kind)
         pse_pkg::KIND_NUMBER: cls.op = pse_pkg::CMD_PUSH;
         pse_pkg::KIND_END:    cls.op = pse_pkg::CMD_END;
         pse_pkg::KIND_OPER: begin
            unique case (req_opcode)
               pse_pkg::CH_PLUS:  cls.op = pse_pkg::CMD_ADD;
               pse_pkg::CH_MINUS: cls.op = pse_pkg::CMD_SUB;
               pse_pkg::CH_STAR:  cls.op = pse_pkg::CMD_MUL;
               pse_pkg::CH_SLASH: cls.op = pse_pkg::CMD_DIV;
               pse_pkg::CH_PCT:   cls.op = pse_pkg::CMD_REM;
               pse_pkg::CH_CARET: cls.op = pse_pkg::CMD_POW;
               pse_pkg::CH_EQ:    cls.op = pse_pkg::CMD_END;
               pse_pkg::CH_SPACE: keep   = 1'b0;
               default:           cls.op = pse_pkg::CMD_UNKNOWN;
            endcase
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && keep;

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[design/pse_back.sv]
// Back end: runs queued commands on the operand stack, with iterative divide and power.
// Depends on pse_pkg, pse_ram and assert_macros.svh.
`include "assert_macros.svh"

module pse_back (
   input  logic                           clock,
   input  logic                           reset,
   input  pse_pkg::cmd_head_type          head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_answer,
   output logic [2:0]                     rsp_status
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_POW  = 3'd3;
   localparam logic [2:0] S_WB   = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   localparam int DW = pse_pkg::DATA_W;
   localparam int AW = pse_pkg::PTR_W;
   localparam int NW = pse_pkg::DEPTH_W;

   logic [2:0]             state_ff, state_in;
   logic [NW-1:0]          depth_ff, depth_in;
   pse_pkg::cmd_op_type    op_ff, op_in;
   logic [DW-1:0]          res_ff, res_in;
   logic [DW-1:0]          quo_ff, quo_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [DW-1:0]          dvs_ff, dvs_in;
   logic [DW-1:0]          acc_ff, acc_in;
   logic [DW-1:0]          sq_ff, sq_in;
   logic [DW-1:0]          exp_ff, exp_in;
   logic                   neg_q_ff, neg_q_in;
   logic                   neg_r_ff, neg_r_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [2:0]             pend_st_ff, pend_st_in;
   logic [DW-1:0]          pend_ans_ff, pend_ans_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]          rsp_answer_ff, rsp_answer_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;
   logic [AW-1:0]          rd_addr_a, rd_addr_b;
   logic [DW-1:0]          opa, opb;
   logic [2*DW-1:0]        mul_ab, mul_acc, mul_sq;
   logic [DW:0]            trial;
   logic                   slot_free;

   pse_ram #(.WIDTH(DW), .DEPTH(pse_pkg::STACK_DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (opa),
      .rd_data_b (opb)
   );

   // operands sit below the top: a at depth-2, b (top) at depth-1
   assign rd_addr_a = AW'(depth_ff - NW'(2));
   assign rd_addr_b = AW'(depth_ff - NW'(1));

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = head.valid && (state_ff == S_IDLE);

   assign mul_ab  = opa * opb;
   assign mul_acc = acc_ff * sq_ff;
   assign mul_sq  = sq_ff * sq_ff;
   assign trial   = {rem_ff, quo_ff[DW-1]} - {1'b0, dvs_ff};

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      exp_in        = exp_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      cnt_in        = cnt_ff;
      pend_st_in    = pend_st_ff;
      pend_ans_in   = pend_ans_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = depth_ff[AW-1:0];
      wr_data       = {1'b0, head.cmd.literal};

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               op_in       = head.cmd.op;
               pend_ans_in = '0;
               unique case (head.cmd.op)
                  pse_pkg::CMD_PUSH: begin
                     if (depth_ff < NW'(pse_pkg::STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        depth_in = depth_ff + NW'(1);
                     end
                  end
                  pse_pkg::CMD_END: begin
                     if (depth_ff == NW'(1)) begin
                        state_in = S_READ;
                     end else begin
                        pend_st_in = pse_pkg::ST_INVALID;
                        state_in   = S_RESP;
                     end
                  end
                  pse_pkg::CMD_UNKNOWN: begin
                     pend_st_in = pse_pkg::ST_UNKNOWN;
                     state_in   = S_RESP;
                  end
                  default: begin
                     if (depth_ff < NW'(2)) begin
                        pend_st_in = pse_pkg::ST_UNDERFLOW;
                        state_in   = S_RESP;
                     end else begin
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end

         // operands are out of the RAM
         S_READ: begin
            unique case (op_ff)
               pse_pkg::CMD_END: begin
                  pend_st_in  = pse_pkg::ST_OK;
                  pend_ans_in = opb;
                  state_in    = S_RESP;
               end
               pse_pkg::CMD_ADD: begin
                  res_in   = opa + opb;
                  state_in = S_WB;
               end
               pse_pkg::CMD_SUB: begin
                  res_in   = opa - opb;
                  state_in = S_WB;
               end
               pse_pkg::CMD_MUL: begin
                  res_in   = mul_ab[DW-1:0];
                  state_in = S_WB;
               end
               pse_pkg::CMD_POW: begin
                  if (opb[DW-1]) begin
                     // negative exponent truncates toward zero
                     if (opa == DW'(1)) begin
                        res_in = DW'(1);
                     end else if (opa == '1) begin
                        res_in = opb[0] ? '1 : DW'(1);
                     end else begin
                        res_in = '0;
                     end
                     state_in = S_WB;
                  end else begin
                     acc_in   = DW'(1);
                     sq_in    = opa;
                     exp_in   = opb;
                     cnt_in   = '0;
                     state_in = S_POW;
                  end
               end
               default: begin
                  // divide and remainder on magnitudes
                  if (opb == '0) begin
                     pend_st_in = pse_pkg::ST_DIVZERO;
                     state_in   = S_RESP;
                  end else begin
                     neg_q_in = opa[DW-1] ^ opb[DW-1];
                     neg_r_in = opa[DW-1];
                     quo_in   = opa[DW-1] ? -opa : opa;
                     dvs_in   = opb[DW-1] ? -opb : opb;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
            endcase
         end

         // restoring division, one quotient bit a cycle
         S_DIV: begin
            if (!trial[DW]) begin
               rem_in = trial[DW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DW-2:0], quo_ff[DW-1]};
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (op_ff == pse_pkg::CMD_DIV) begin
                  res_in = neg_q_ff ? -quo_in : quo_in;
               end else begin
                  res_in = neg_r_ff ? -rem_in : rem_in;
               end
               state_in = S_WB;
            end
         end

         // square and multiply, one exponent bit a cycle
         S_POW: begin
            if (exp_ff[0]) begin
               acc_in = mul_acc[DW-1:0];
            end
            sq_in  = mul_sq[DW-1:0];
            exp_in = {1'b0, exp_ff[DW-1:1]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               res_in   = acc_in;
               state_in = S_WB;
            end
         end

         // result replaces the two operands
         S_WB: begin
            wr_en    = 1'b1;
            wr_addr  = rd_addr_a;
            wr_data  = res_ff;
            depth_in = depth_ff - NW'(1);
            state_in = S_IDLE;
         end

         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = pend_ans_ff;
               rsp_status_in = pend_st_ff;
               depth_in      = '0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      res_ff        <= res_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      exp_ff        <= exp_in;
      neg_q_ff      <= neg_q_in;
      neg_r_ff      <= neg_r_in;
      cnt_ff        <= cnt_in;
      pend_st_ff    <= pend_st_in;
      pend_ans_ff   <= pend_ans_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   `PSE_ASSERT(a_depth_bound, depth_ff <= NW'(pse_pkg::STACK_DEPTH), "stack depth overflow")
   `PSE_ASSERT_NXT(a_resp_clears, (state_ff == S_RESP) && slot_free, depth_ff == '0 && rsp_valid, "result did not clear stack")
   `PSE_ASSERT_NXT(a_wb_pops, state_ff == S_WB, depth_ff == $past(depth_ff) - NW'(1), "write-back did not pop one")

endmodule

[dv/tb_postfix_stack_evaluator.sv]
// Testbench for postfix_stack_evaluator: directed token table, then random expressions.
// Results are checked against an in-bench stack predictor. Depends on pse_pkg.
module tb_postfix_stack_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_token_kind = '0;
   logic [pse_pkg::LIT_W-1:0] req_literal = '0;
   logic [7:0] req_opcode = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_answer;
   logic [2:0] rsp_status;

   postfix_stack_evaluator u_dut (.*);

   always #1 clock = ~clock;

   typedef struct packed {
      logic [31:0] answer;
      logic [2:0]  status;
   } outcome_type;

   typedef struct {
      logic [1:0]                kind;
      logic [pse_pkg::LIT_W-1:0] lit;
      logic [7:0]                op;
      logic                      fixed;  // expected result typed in
      logic [31:0]               answer;
      logic [2:0]                status;
   } token_row_type;

   // predictor state
   logic [31:0] operands [pse_pkg::STACK_DEPTH];
   int unsigned depth_q;
   outcome_type pending_outcomes [$];
   int mismatches = 0;
   int result_count = 0;
   int token_count = 0;
   bit quiet_mode = 0;  // long stretch with no idling

   function automatic logic [31:0] pow32(logic [31:0] base, logic [31:0] expo);
      logic [31:0] acc, sq;
      acc = 32'd1;
      sq = base;
      if (expo[31]) begin
         if (base == 32'd1) return 32'd1;
         if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      for (int i = 0; i < 31; i++) begin
         if (expo[i]) acc = acc * sq;
         sq = sq * sq;
      end
      return acc;
   endfunction

   // Apply one token to the predicted stack; returns 1 when a result is due.
   function automatic bit eval_token(input logic [1:0] kind,
                                     input logic [pse_pkg::LIT_W-1:0] lit,
                                     input logic [7:0] op, output outcome_type res);
      logic [31:0] a, b, r;
      logic signed [31:0] sa, sb;
      res = '0;
      if (kind == pse_pkg::KIND_NUMBER) begin
         if (depth_q < pse_pkg::STACK_DEPTH) begin
            operands[depth_q] = {1'b0, lit};
            depth_q++;
         end
         return 0;
      end
      if (kind == pse_pkg::KIND_OPER && op == pse_pkg::CH_SPACE) return 0;
      if (kind != pse_pkg::KIND_END && kind != pse_pkg::KIND_OPER) return 0;
      if (kind == pse_pkg::KIND_END || op == pse_pkg::CH_EQ) begin
         if (depth_q == 1) res = '{operands[0], pse_pkg::ST_OK};
         else res = '{32'd0, pse_pkg::ST_INVALID};
         depth_q = 0;
         return 1;
      end
      if (!(op inside {pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_STAR,
                       pse_pkg::CH_SLASH, pse_pkg::CH_CARET, pse_pkg::CH_PCT})) begin
         res = '{32'd0, pse_pkg::ST_UNKNOWN};
         depth_q = 0;
         return 1;
      end
      if (depth_q < 2) begin
         res = '{32'd0, pse_pkg::ST_UNDERFLOW};
         depth_q = 0;
         return 1;
      end
      b = operands[depth_q-1];
      a = operands[depth_q-2];
      sa = a;
      sb = b;
      case (op)
         pse_pkg::CH_PLUS:  r = a + b;
         pse_pkg::CH_MINUS: r = a - b;
         pse_pkg::CH_STAR:  r = a * b;
         pse_pkg::CH_CARET: r = pow32(a, b);
         default: begin
            if (b == 0) begin
               res = '{32'd0, pse_pkg::ST_DIVZERO};
               depth_q = 0;
               return 1;
            end
            // most negative over minus one wraps
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
               r = (op == pse_pkg::CH_SLASH) ? 32'h8000_0000 : 32'd0;
            else
               r = (op == pse_pkg::CH_SLASH) ? sa / sb : sa % sb;
         end
      endcase
      depth_q--;
      operands[depth_q-1] = r;
      return 0;
   endfunction

   // Drive one transaction; predicted result goes into the queue.
   // Called and returns at a falling edge; valid stays up until the next call or idle.
   task automatic send_token(token_row_type t);
      outcome_type res;
      outcome_type typed;
      bit due;
      while (!quiet_mode && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      due = eval_token(t.kind, t.lit, t.op, res);
      typed = outcome_type'{t.answer, t.status};
      if (t.fixed && (!due || res != typed))
         $display("table row disagrees with predictor: kind %0d op %h", t.kind, t.op);
      if (due) pending_outcomes.push_back(t.fixed ? typed : res);
      req_valid <= 1'b1;
      req_token_kind <= t.kind;
      req_literal <= t.lit;
      req_opcode <= t.op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      token_count++;
      @(negedge clock);
   endtask

   function automatic token_row_type num(logic [pse_pkg::LIT_W-1:0] v);
      return '{pse_pkg::KIND_NUMBER, v, 8'h00, 1'b0, 32'd0, pse_pkg::ST_OK};
   endfunction
   function automatic token_row_type oper(logic [7:0] c);
      return '{pse_pkg::KIND_OPER, pse_pkg::LIT_W'(0), c, 1'b0, 32'd0, pse_pkg::ST_OK};
   endfunction
   function automatic token_row_type end_token();
      return '{pse_pkg::KIND_END, pse_pkg::LIT_W'(0), 8'h00, 1'b0, 32'd0, pse_pkg::ST_OK};
   endfunction
   function automatic token_row_type known(logic [1:0] k, logic [7:0] c, logic [31:0] ans,
                                           logic [2:0] st);
      return '{k, {pse_pkg::LIT_W{1'b1}}, c, 1'b1, ans, st};
   endfunction

   // result side backpressure
   always @(negedge clock) begin
      if (!reset && !quiet_mode) rsp_ready <= ($urandom_range(99) >= 38);
      else if (!reset) rsp_ready <= 1'b1;
   end

   // result checking
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d/%0d", rsp_answer, rsp_status);
         end else begin
            want = pending_outcomes.pop_front();
            if (want.answer != rsp_answer || want.status != rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected answer %h status %0d, got %h status %0d",
                           want.answer, want.status, rsp_answer, rsp_status);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAIL postfix_stack_evaluator");
      $finish;
   end

   initial begin
      token_row_type directed [$];
      token_row_type t;
      int n, len;
      logic [7:0] ops [6];
      ops = '{pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_STAR, pse_pkg::CH_SLASH,
              pse_pkg::CH_CARET, pse_pkg::CH_PCT};
      depth_q = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      directed = '{
         known(pse_pkg::KIND_END, 8'h00, 32'd0, pse_pkg::ST_INVALID),  // end on empty stack
         num('1), known(pse_pkg::KIND_END, 8'h00, 32'h7FFF_FFFF, pse_pkg::ST_OK),
         num(0), known(pse_pkg::KIND_OPER, pse_pkg::CH_EQ, 32'd0, pse_pkg::ST_OK),
         known(pse_pkg::KIND_OPER, pse_pkg::CH_PLUS, 32'd0, pse_pkg::ST_UNDERFLOW),
         known(pse_pkg::KIND_OPER, 8'hFF, 32'd0, pse_pkg::ST_UNKNOWN),
         num(7), num(0), known(pse_pkg::KIND_OPER, pse_pkg::CH_SLASH, 32'd0,
                               pse_pkg::ST_DIVZERO),
         num(0), num(1), oper(pse_pkg::CH_MINUS), num(1), oper(pse_pkg::CH_SLASH),
         '{2'd3, '1, 8'hAA, 1'b0, 32'd0, pse_pkg::ST_OK}, oper(pse_pkg::CH_SPACE),
         oper(pse_pkg::CH_PCT), oper(pse_pkg::CH_EQ)
      };
      foreach (directed[i]) send_token(directed[i]);
      // wrap cases: min / -1, negative exponent, power, multiply
      directed = '{num(0), num('1), oper(pse_pkg::CH_MINUS), num(1), oper(pse_pkg::CH_MINUS),
                   num(0), num(1), oper(pse_pkg::CH_MINUS), oper(pse_pkg::CH_SLASH),
                   oper(pse_pkg::CH_EQ),
                   num(2), num(0), num(3), oper(pse_pkg::CH_MINUS), oper(pse_pkg::CH_CARET),
                   oper(pse_pkg::CH_EQ),
                   num(0), num(0), oper(pse_pkg::CH_CARET), num(3), num(40),
                   oper(pse_pkg::CH_CARET), oper(pse_pkg::CH_STAR), oper(pse_pkg::CH_EQ)};
      foreach (directed[i]) send_token(directed[i]);
      // full stack drops extra pushes
      for (int i = 0; i < pse_pkg::STACK_DEPTH + 2; i++) send_token(num(i));
      send_token(oper(pse_pkg::CH_STAR));
      send_token(oper(pse_pkg::CH_EQ));

      // pause until drained
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_outcomes.size() != 0) @(negedge clock);

      n = 0;
      while (n < 650) begin
         quiet_mode = (n >= 300 && n < 380);
         if ($urandom_range(9) < 8) begin
            // well-formed expression with random content
            len = $urandom_range(1, 6);
            send_token(num($urandom_range(9) < 4 ? pse_pkg::LIT_W'($urandom) :
                           pse_pkg::LIT_W'($urandom_range(9))));
            for (int k = 1; k < len; k++) begin
               send_token(num($urandom_range(9) < 3 ? pse_pkg::LIT_W'($urandom) :
                              pse_pkg::LIT_W'($urandom_range(12))));
               t = oper(ops[$urandom_range(5)]);
               send_token(t);
               n += 2;
            end
            send_token($urandom_range(1) ? oper(pse_pkg::CH_EQ) : end_token());
            n += 2;
         end else begin
            t = '{2'($urandom), pse_pkg::LIT_W'($urandom), 8'($urandom), 1'b0, 32'd0,
                  pse_pkg::ST_OK};
            if ($urandom_range(1)) t.op = ops[$urandom_range(5)];
            send_token(t);
            n++;
         end
      end
      quiet_mode = 0;
      send_token(oper(pse_pkg::CH_EQ));
      req_valid <= 1'b0;
      @(negedge clock);

      fork
         while (pending_outcomes.size() != 0) @(negedge clock);
      join
      repeat (80) @(negedge clock);
      $display("covered %0d tokens, %0d results: all operators, error codes, full stack",
               token_count, result_count);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("PASS postfix_stack_evaluator");
      else
         $display("FAIL postfix_stack_evaluator");
      $finish;
   end
endmodule
